// ===== sv/assert_macros.svh =====
// assertion helpers for the sensor conditioner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== sv/sanh_pkg.sv =====
// ----------------------------------------------------------------------------
// sanh_pkg
// shared types and constants of the sensor conditioner
// ----------------------------------------------------------------------------
package sanh_pkg;
  localparam int unsigned Channels = 6;
  localparam int unsigned Window = 8;
  localparam int unsigned ChW = 3;
  localparam int unsigned PosW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned SumW = 10 + PosW + ((Window & (Window - 1)) != 0 ? 1 : 0);
  localparam int unsigned RingD = Channels * Window;
  localparam int unsigned RingAw = $clog2(RingD);
  localparam int unsigned QDepth = 2;
  localparam logic [9:0] RawMax = 10'd1023;
  localparam logic [6:0] LevelFull = 7'd100;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ON  = 2'd0,
    REG_OFF = 2'd1,
    REG_SPAN = 2'd2,
    REG_INV = 2'd3
  } reg_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       valid_ch;
    logic [2:0] ch;
    logic [9:0] sample;
    logic       learn;
    logic       drive;
  } job_t;

  typedef struct packed {
    logic [6:0] on_thr;
    logic [6:0] off_thr;
    logic [9:0] min_span;
    logic       invert;
  } cfg_t;

  typedef struct packed {
    logic [2:0] ch;
    logic [9:0] avg;
    logic [9:0] mn;
    logic [9:0] mx;
    logic [6:0] lvl;
    logic       lamp;
    logic       ok;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_e;
endpackage

// ===== sv/sensor_average_normalize_hysteresis.sv =====
// ----------------------------------------------------------------------------
// sensor_average_normalize_hysteresis
// multi-channel moving average, min/max calibration, level and lamp latch
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tuser: command; tdata: channel, sample, learn, drive_led
// m_axis    out  tdata: out_channel, average, minimum, maximum, level, lamp_on, span_ok
// cfg       in   wr_en_i, wr_idx_i, wr_data_i
// a restart or bad-channel beat steps through idle, read and out; a sample adds update
// and the serial divide (one quotient bit a cycle), and a first sample fills the ring first
// a two-entry job queue lets beats enter while a result waits on m_axis
// reset clears sums, learned range and latches and loads the default configuration at once
module sensor_average_normalize_hysteresis (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,  // command
  input  logic [15:0] s_axis_tdata,  // channel, sample, learn, drive_led, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_channel, average, minimum, maximum,
                                     // level, lamp_on, span_ok, zero fill
  input  logic        wr_en_i,
  input  logic [1:0]  wr_idx_i,
  input  logic [9:0]  wr_data_i
);
  import sanh_pkg::*;

  cfg_t cfg_q;
  job_t job;
  logic job_valid, job_pop;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_thr   <= 7'd80;
      cfg_q.off_thr  <= 7'd70;
      cfg_q.min_span <= 10'd60;
      cfg_q.invert   <= 1'b1;
    end else if (wr_en_i) begin
      case (reg_e'(wr_idx_i))
        REG_ON:   cfg_q.on_thr   <= wr_data_i[6:0];
        REG_OFF:  cfg_q.off_thr  <= wr_data_i[6:0];
        REG_SPAN: cfg_q.min_span <= wr_data_i;
        REG_INV:  cfg_q.invert   <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  sanh_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_user_i(s_axis_tuser), .in_data_i(s_axis_tdata),
    .job_o(job), .job_valid_o(job_valid), .job_pop_i(job_pop)
  );

  sanh_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .job_i(job), .job_valid_i(job_valid), .job_pop_o(job_pop),
    .res_o(res), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, res.ok, res.lamp, res.lvl, res.mx, res.mn, res.avg, res.ch};
endmodule

// ===== sv/sanh_front.sv =====
// ----------------------------------------------------------------------------
// sanh_front
// accepts beats, classifies the channel, queues jobs for the back end
// ----------------------------------------------------------------------------
module sanh_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           in_user_i,
  input  logic [15:0]    in_data_i,
  output sanh_pkg::job_t job_o,
  output logic           job_valid_o,
  input  logic           job_pop_i
);
  import sanh_pkg::*;

  job_t      q_mem [QDepth];
  logic [1:0] cnt_q, cnt_d;
  logic      rd_q, wr_q;
  logic      push;
  job_t      nj;

  always_comb begin
    nj.cmd      = cmd_e'(in_user_i);
    nj.ch       = in_data_i[2:0];
    nj.valid_ch = (32'(in_data_i[2:0]) < Channels);
    nj.sample   = in_data_i[12:3];
    nj.learn    = in_data_i[13];
    nj.drive    = in_data_i[14];
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(job_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (job_pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= nj;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_pop_empty, !(job_pop_i && cnt_q == 2'd0))
  `ASSERT_IMPL(a_cnt_range, cnt_q <= 2'(QDepth))
endmodule

// ===== sv/sanh_back.sv =====
// ----------------------------------------------------------------------------
// sanh_back
// runs one job: ring update, calibration, serial divide, hysteresis
// ----------------------------------------------------------------------------
module sanh_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sanh_pkg::cfg_t cfg_i,
  input  sanh_pkg::job_t job_i,
  input  logic           job_valid_i,
  output logic           job_pop_o,
  output sanh_pkg::res_t res_o,
  output logic           res_valid_o,
  input  logic           res_ready_i
);
  import sanh_pkg::*;

  logic [9:0]        ring [RingD];
  logic [PosW-1:0]   wpos_q [Channels];
  logic [Channels-1:0] primed_q, lamp_q;
  logic [SumW-1:0]   sum_q [Channels];
  logic [9:0]        mn_q [Channels];
  logic [9:0]        mx_q [Channels];

  state_e state_q, state_d;
  job_t   j_q;
  logic [9:0] old_q;
  logic [PosW-1:0] fill_q;
  logic [9:0] span_q;
  logic [16:0] rem_q;
  logic [6:0]  quo_q;
  logic [16:0] num_q;
  logic [4:0]  bit_q;
  res_t res_q;
  logic rv_q;

  logic [2:0] c;
  logic [RingAw-1:0] base;
  logic [SumW-1:0] nsum;
  logic [9:0] navg, nmn, nmx, nspan;
  logic nok;
  logic [16:0] trial;
  logic [6:0] lvl;

  assign c    = j_q.ch;
  assign base = RingAw'(32'(c) * Window);

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: if (job_valid_i && !rv_q) begin
        job_pop_o = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        if (!j_q.valid_ch || j_q.cmd == CMD_RESTART) state_d = ST_OUT;
        else if (!primed_q[c]) state_d = ST_FILL;
        else state_d = ST_UPD;
      end
      ST_FILL: if (32'(fill_q) == Window - 1) state_d = ST_UPD;
      ST_UPD:  state_d = ST_DIV;
      ST_DIV:  if (bit_q == 5'd0) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // new sum, average, min/max (learned only with learn), span and span check after this sample
  always_comb begin
    if (!primed_q[c]) nsum = SumW'(32'(j_q.sample) * Window);
    else nsum = sum_q[c] - SumW'(old_q) + SumW'(j_q.sample);
    navg = 10'(nsum / Window);
    nmn = mn_q[c];
    nmx = mx_q[c];
    if (j_q.learn) begin
      if (navg < nmn) nmn = navg;
      if (navg > nmx) nmx = navg;
    end
    nspan = nmx - nmn;
    nok = (nmx >= nmn) && (nspan >= cfg_i.min_span);
  end

  assign trial = {rem_q[15:0], num_q[16]} - {7'd0, span_q};
  assign lvl = (quo_q > LevelFull) ? LevelFull : quo_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) old_q <= ring[base + RingAw'(wpos_q[c])];
    if (state_q == ST_FILL) ring[base + RingAw'(fill_q)] <= j_q.sample;
    if (state_q == ST_UPD && primed_q[c]) ring[base + RingAw'(wpos_q[c])] <= j_q.sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      primed_q <= '0;
      lamp_q   <= '0;
      rv_q     <= 1'b0;
      fill_q   <= '0;
      for (int i = 0; i < Channels; i++) begin
        wpos_q[i] <= '0;
        sum_q[i]  <= '0;
        mn_q[i]   <= RawMax;
        mx_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (rv_q && res_ready_i) rv_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (job_pop_o) begin
          j_q <= job_i;
          fill_q <= '0;
        end
        ST_READ: begin
          res_q.ch <= j_q.ch;
          res_q.avg <= '0; res_q.mn <= '0; res_q.mx <= '0;
          res_q.lvl <= '0; res_q.lamp <= 1'b0; res_q.ok <= 1'b0;
          if (j_q.valid_ch && j_q.cmd == CMD_RESTART) begin
            mn_q[c] <= RawMax;
            mx_q[c] <= '0;
            res_q.avg <= 10'(sum_q[c] / Window);
            res_q.mn <= RawMax;
            res_q.lamp <= lamp_q[c];
          end
        end
        ST_FILL: fill_q <= fill_q + PosW'(1);
        ST_UPD: begin
          sum_q[c] <= nsum;
          mn_q[c] <= nmn;
          mx_q[c] <= nmx;
          if (!primed_q[c]) wpos_q[c] <= '0;
          else wpos_q[c] <= (32'(wpos_q[c]) + 1 >= Window) ? '0 : wpos_q[c] + PosW'(1);
          primed_q[c] <= 1'b1;
          span_q <= nspan;
          res_q.avg <= navg; res_q.mn <= nmn; res_q.mx <= nmx;
          res_q.ok <= nok;
          rem_q <= '0;
          quo_q <= '0;
          bit_q <= 5'd16;
          if (!nok || nspan == 10'd0) num_q <= '0;
          else if (cfg_i.invert)
            num_q <= (navg >= nmx) ? 17'd0 : 17'(nmx - navg) * 17'd100;
          else
            num_q <= (navg <= nmn) ? 17'd0 : 17'(navg - nmn) * 17'd100;
        end
        ST_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (span_q == 10'd0) begin
            quo_q <= '0;
          end else if (!trial[16]) begin
            rem_q <= trial;
            quo_q <= (quo_q[6] ? 7'd127 : {quo_q[5:0], 1'b1});
          end else begin
            rem_q <= {rem_q[15:0], num_q[16]};
            quo_q <= (quo_q[6] ? 7'd127 : {quo_q[5:0], 1'b0});
          end
          num_q <= {num_q[15:0], 1'b0};
          bit_q <= bit_q - 5'd1;
        end
        ST_OUT: begin
          rv_q <= 1'b1;
          if (j_q.valid_ch && j_q.cmd == CMD_SAMPLE) begin
            res_q.lvl <= lvl;
            if (j_q.drive) begin
              if (lvl >= cfg_i.on_thr) begin
                lamp_q[c] <= 1'b1; res_q.lamp <= 1'b1;
              end else if (lvl < cfg_i.off_thr) begin
                lamp_q[c] <= 1'b0; res_q.lamp <= 1'b0;
              end else res_q.lamp <= lamp_q[c];
            end else res_q.lamp <= lamp_q[c];
          end
        end
        default: ;
      endcase
    end
  end

  assign res_o = res_q;
  assign res_valid_o = rv_q;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_pop_read, job_pop_o, state_q == ST_READ)
  `ASSERT_IMPL(a_min_max_restart, !(state_q == ST_OUT && res_q.ok && res_q.mx < res_q.mn))
  `ASSERT_NEXT(a_out_valid, state_q == ST_OUT, rv_q)
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the sensor conditioner against a behavioral predictor of the
// moving average, learned range, level and lamp latch, with random stalls
// ----------------------------------------------------------------------------
module tb_top;
  import sanh_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = 1'b0;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        wr_en_i = 1'b0;
  logic [1:0]  wr_idx_i = '0;
  logic [9:0]  wr_data_i = '0;

  sensor_average_normalize_hysteresis dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [9:0]  ring_q [Channels*Window];
  logic [2:0]  wpos_q [Channels];
  logic        primed_q [Channels];
  logic [12:0] sum_q [Channels];
  logic [9:0]  min_q [Channels];
  logic [9:0]  max_q [Channels];
  logic        lamp_q [Channels];
  logic [6:0]  on_thr, off_thr;
  logic [9:0]  span_min;
  logic        invert;

  res_t expected_q [$];
  int   n_fail = 0;

  function automatic res_t predict_result(cmd_e cmd, logic [2:0] ch, logic [9:0] smp,
                                          logic learn, logic drive);
    res_t r;
    int unsigned avg, lo, hi, span, num, lvl, pos;
    r = '0;
    r.ch = ch;
    if (ch >= Channels) return r;
    if (cmd == CMD_RESTART) begin
      min_q[ch] = RawMax;
      max_q[ch] = '0;
      r.avg = 10'(sum_q[ch] / Window);
    end else begin
      if (!primed_q[ch]) begin
        for (int i = 0; i < Window; i++) ring_q[ch*Window+i] = smp;
        sum_q[ch] = 13'(smp * Window);
        wpos_q[ch] = '0;
        primed_q[ch] = 1'b1;
      end else begin
        pos = ch * Window + wpos_q[ch];
        sum_q[ch] = sum_q[ch] - 13'(ring_q[pos]) + 13'(smp);
        ring_q[pos] = smp;
        wpos_q[ch] = (wpos_q[ch] + 1 >= Window) ? 3'd0 : wpos_q[ch] + 3'd1;
      end
      avg = 32'(sum_q[ch]) / Window;
      if (learn) begin
        if (avg < min_q[ch]) min_q[ch] = 10'(avg);
        if (avg > max_q[ch]) max_q[ch] = 10'(avg);
      end
      lo = 32'(min_q[ch]);
      hi = 32'(max_q[ch]);
      lvl = 0;
      if (hi >= lo && hi - lo >= span_min) begin
        r.ok = 1'b1;
        span = hi - lo;
        if (span != 0) begin
          if (invert) num = (avg >= hi) ? 0 : (hi - avg) * 100;
          else num = (avg <= lo) ? 0 : (avg - lo) * 100;
          lvl = num / span;
          if (lvl > 100) lvl = 100;
        end
      end
      if (drive) begin
        if (lvl >= on_thr) lamp_q[ch] = 1'b1;
        else if (lvl < off_thr) lamp_q[ch] = 1'b0;
      end
      r.avg = 10'(avg);
      r.lvl = 7'(lvl);
    end
    r.mn = min_q[ch];
    r.mx = max_q[ch];
    r.lamp = lamp_q[ch];
    return r;
  endfunction

  // valid stays high into the next beat when no idle cycles are drawn
  task automatic send_sample(cmd_e cmd, logic [2:0] ch, logic [9:0] smp,
                             logic learn, logic drive);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {1'b0, drive, learn, smp, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_result(cmd, ch, smp, learn, drive));
  endtask

  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [9:0] val);
    wr_en_i <= 1'b1;
    wr_idx_i <= idx;
    wr_data_i <= val;
    @(posedge clk_i);
    wr_en_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_ON:   on_thr = val[6:0];
      REG_OFF:  off_thr = val[6:0];
      REG_SPAN: span_min = val;
      REG_INV:  invert = val[0];
      default:  ;
    endcase
  endtask

  task automatic test_directed;
    // first samples at both rails, bad channels, restart before priming
    send_sample(CMD_RESTART, 3'd5, 10'd0, 1'b0, 1'b1);
    send_sample(CMD_SAMPLE, 3'd0, 10'd0, 1'b1, 1'b1);
    send_sample(CMD_SAMPLE, 3'd1, 10'd1023, 1'b1, 1'b1);
    send_sample(CMD_SAMPLE, 3'd6, 10'd1023, 1'b1, 1'b1);
    send_sample(CMD_RESTART, 3'd7, 10'h3ff, 1'b1, 1'b1);
    for (int i = 0; i < 8; i++) send_sample(CMD_SAMPLE, 3'd0, 10'd1023, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) send_sample(CMD_SAMPLE, 3'd0, 10'd0, i[0], 1'b1);
    send_sample(CMD_SAMPLE, 3'd1, 10'd1023, 1'b0, 1'b0);
    send_sample(CMD_RESTART, 3'd0, 10'd0, 1'b0, 1'b1);
    send_sample(CMD_SAMPLE, 3'd0, 10'd512, 1'b1, 1'b1);
    drain_results();
  endtask

  task automatic run_random(int n);
    int unsigned ch, smp;
    for (int i = 0; i < n; i++) begin
      ch = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
      smp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
          : (ch * 150 + $urandom_range(0, 200)) % 1024;
      send_sample(($urandom_range(0, 24) == 0) ? CMD_RESTART : CMD_SAMPLE, 3'(ch), 10'(smp),
                  $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0);
    end
    drain_results();
  endtask

  task automatic test_settings;
    run_random(300);
    write_reg(REG_ON, 10'd100); write_reg(REG_OFF, 10'd0);
    write_reg(REG_SPAN, 10'd0); write_reg(REG_INV, 10'd0);
    run_random(300);
    write_reg(REG_ON, 10'd0); write_reg(REG_OFF, 10'd100);
    write_reg(REG_SPAN, 10'd1023); write_reg(REG_INV, 10'd1);
    run_random(150);
    write_reg(REG_ON, 10'd50); write_reg(REG_OFF, 10'd40);
    write_reg(REG_SPAN, 10'd5); write_reg(REG_INV, 10'd0);
    run_random(480);
  endtask

  // result checker with random stalls
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got.ch   = m_axis_tdata[2:0];
      got.avg  = m_axis_tdata[12:3];
      got.mn   = m_axis_tdata[22:13];
      got.mx   = m_axis_tdata[32:23];
      got.lvl  = m_axis_tdata[39:33];
      got.lamp = m_axis_tdata[40];
      got.ok   = m_axis_tdata[41];
      if (expected_q.size() == 0) begin
        $error("unexpected result beat %h", got);
        n_fail++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.ch !== exp_r.ch) begin
          $error("out_channel exp %0d got %0d", exp_r.ch, got.ch); n_fail++; end
        if (got.avg !== exp_r.avg) begin
          $error("average exp %0d got %0d", exp_r.avg, got.avg); n_fail++; end
        if (got.mn !== exp_r.mn) begin
          $error("minimum exp %0d got %0d", exp_r.mn, got.mn); n_fail++; end
        if (got.mx !== exp_r.mx) begin
          $error("maximum exp %0d got %0d", exp_r.mx, got.mx); n_fail++; end
        if (got.lvl !== exp_r.lvl) begin
          $error("level exp %0d got %0d", exp_r.lvl, got.lvl); n_fail++; end
        if (got.lamp !== exp_r.lamp) begin
          $error("lamp_on exp %0d got %0d", exp_r.lamp, got.lamp); n_fail++; end
        if (got.ok !== exp_r.ok) begin
          $error("span_ok exp %0d got %0d", exp_r.ok, got.ok); n_fail++; end
      end
    end
  end

  // ready stall: holds a drawn level for a drawn number of cycles
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_cnt <= $urandom_range(0, 12);
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
  end

  initial begin
    on_thr = 7'd80; off_thr = 7'd70; span_min = 10'd60; invert = 1'b1;
    for (int c = 0; c < Channels; c++) begin
      wpos_q[c] = '0; primed_q[c] = 1'b0; sum_q[c] = '0;
      min_q[c] = RawMax; max_q[c] = '0; lamp_q[c] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("sensor_average_normalize_hysteresis test passed");
    end else begin
      $display("sensor_average_normalize_hysteresis test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("sensor_average_normalize_hysteresis test failed");
    $finish;
  end
endmodule
